// ===== rtl/core/cluster_link_search_and_merge_unit_macros.svh =====
// Assertion macros for the cluster link search and merge unit.
`ifndef CLUSTER_LINK_SEARCH_AND_MERGE_UNIT_MACROS_SVH
`define CLUSTER_LINK_SEARCH_AND_MERGE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CLSM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CLSM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/clsm_pkg.sv =====
// Shared constants and codes for the cluster link search and merge unit.
package clsm_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int NV_W         = VTX_W + 1;
    localparam int MAX_EDGES    = 256;
    localparam int EDGE_W       = $clog2(MAX_EDGES);
    localparam int ECNT_W       = EDGE_W + 1;
    localparam int DIST_BITS    = 16;
    localparam int DADDR_W      = 2 * VTX_W;
    localparam int DIST_DEPTH   = 1 << DADDR_W;
    localparam int CLR_W        = DADDR_W + 1;
    localparam int FUNC_W       = 2;
    localparam int STAT_W       = 2;
    localparam int CFG_IDX_W    = 1;

    localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_FIND  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_MERGE = 2'd2;

    localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STAT_W-1:0] STAT_MISSING = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOLINK  = 2'd2;
    localparam logic [STAT_W-1:0] STAT_FULL    = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_VERTICES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PICK_LONGEST = 1'b1;

endpackage

// ===== rtl/core/cluster_link_search_and_merge_unit.sv =====
// Cluster link search and merge engine: load edges, find cluster links, merge clusters.
// After reset a clearing sweep wipes all 4096 entries of the distance store and relabels every
// vertex as its own cluster; no item is accepted until it ends. Reset is synchronous, active low.
// One item at a time; a find builds member masks over all 64 labels, then scans the nv by nv
// pairs (nv vertices in use; one vertex pair read per cycle) and walks the edge list.
// Configuration returns to 64 vertices, shortest connection.
module cluster_link_search_and_merge_unit
    import clsm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // input item channel
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [FUNC_W-1:0]    i_func,
    input  logic [VTX_W-1:0]     i_vertex_a,
    input  logic [VTX_W-1:0]     i_vertex_b,
    input  logic [DIST_BITS-1:0] i_distance,
    input  logic [VTX_W-1:0]     i_cluster_a,
    input  logic [VTX_W-1:0]     i_cluster_b,
    // result item channel
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [EDGE_W-1:0]    o_edge_index,
    output logic [DIST_BITS-1:0] o_best_distance,
    output logic [STAT_W-1:0]    o_status,
    // configuration write port
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [NV_W-1:0]      i_cfg_data
);

`include "cluster_link_search_and_merge_unit_macros.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CHK  = 4'd1;  // cluster checks, dispatch
    localparam logic [3:0] S_LD0  = 4'd2;  // edge append + forward distance
    localparam logic [3:0] S_LD1  = 4'd3;  // backward distance
    localparam logic [3:0] S_FM   = 4'd4;  // build member masks
    localparam logic [3:0] S_FS   = 4'd5;  // pair scan
    localparam logic [3:0] S_FE   = 4'd6;  // edge list search
    localparam logic [3:0] S_MG   = 4'd7;  // relabel sweep
    localparam logic [3:0] S_DONE = 4'd8;  // hand result to output register

    // ---------------------------------------------------------------
    // Configuration and control state
    // ---------------------------------------------------------------
    logic [3:0]              r_state;
    logic [NV_W-1:0]         r_nv_cfg;
    logic                    r_pick;
    logic [MAX_VERTICES-1:0] r_live;
    logic [ECNT_W-1:0]       r_edge_cnt;
    logic [CLR_W-1:0]        r_clr_cnt;
    logic                    r_issue;

    // latched item
    logic [FUNC_W-1:0]       r_func;
    logic [VTX_W-1:0]        r_va, r_vb, r_ca, r_cb;
    logic [DIST_BITS-1:0]    r_dist;

    // sweep indices and the one-deep read pipeline behind them
    logic [VTX_W-1:0]        r_v, r_i, r_j;
    logic [EDGE_W-1:0]       r_k;
    logic                    r_p_act, r_p_v, r_p_last;
    logic [VTX_W-1:0]        r_p_i, r_p_j;
    logic [EDGE_W-1:0]       r_p_k;

    // find bookkeeping
    logic [MAX_VERTICES-1:0] r_mask_a, r_mask_b;
    logic                    r_found;
    logic [DIST_BITS-1:0]    r_best;
    logic [VTX_W-1:0]        r_bi, r_bj;

    // pending result and output register
    logic [EDGE_W-1:0]       r_res_idx;
    logic [DIST_BITS-1:0]    r_res_dist;
    logic [STAT_W-1:0]       r_res_stat;
    logic                    r_out_v;
    logic [EDGE_W-1:0]       r_out_idx;
    logic [DIST_BITS-1:0]    r_out_dist;
    logic [STAT_W-1:0]       r_out_stat;

    // ---------------------------------------------------------------
    // Memories: cluster label per vertex, distance store, edge list
    // ---------------------------------------------------------------
    logic [VTX_W-1:0]       m_cov [MAX_VERTICES];
    logic [DIST_BITS:0]     m_dist [DIST_DEPTH];     // {present, distance}
    logic [2*VTX_W-1:0]     m_edge [MAX_EDGES];      // {from, to}

    logic                   cov_we;
    logic [VTX_W-1:0]       cov_wa, cov_wd, cov_ra;
    logic [VTX_W-1:0]       r_cov_rd;

    logic                   dist_we;
    logic [DADDR_W-1:0]     dist_wa;
    logic [DIST_BITS:0]     dist_wd;
    logic [DIST_BITS:0]     r_fw_rd, r_bw_rd;

    logic                   edge_we;
    logic [2*VTX_W-1:0]     r_edge_rd;

    // ---------------------------------------------------------------
    // Derived values
    // ---------------------------------------------------------------
    logic                   clr_busy;
    logic [NV_W-1:0]        nv, nv_m1;
    logic                   ca_ok, cb_ok, ld_range_ok, ld_full, ld_ok;
    logic                   scan_last, fe_last, mg_last;
    logic                   n_found;
    logic [DIST_BITS-1:0]   n_best;
    logic [VTX_W-1:0]       n_bi, n_bj;
    logic [DIST_BITS-1:0]   fw_d, bw_d;
    logic                   fw_take, bw_take, edge_hit;
    logic                   out_free;

    assign clr_busy = !r_clr_cnt[CLR_W-1];

    // vertices in use, clamped to 1..MAX_VERTICES
    always_comb begin
        if (r_nv_cfg == '0) begin
            nv = NV_W'(1);
        end else if (r_nv_cfg > NV_W'(MAX_VERTICES)) begin
            nv = NV_W'(MAX_VERTICES);
        end else begin
            nv = r_nv_cfg;
        end
    end
    assign nv_m1 = nv - NV_W'(1);

    assign ca_ok = ({1'b0, r_ca} < nv) && r_live[r_ca];
    assign cb_ok = ({1'b0, r_cb} < nv) && r_live[r_cb];
    assign ld_range_ok = ({1'b0, r_va} < nv) && ({1'b0, r_vb} < nv);
    assign ld_full     = (r_edge_cnt == ECNT_W'(MAX_EDGES));
    assign ld_ok       = (r_state == S_LD0) && ld_range_ok && !ld_full;

    assign scan_last = ({1'b0, r_i} == nv_m1) && ({1'b0, r_j} == nv_m1);
    assign fe_last   = ({1'b0, r_k} == r_edge_cnt - ECNT_W'(1));
    assign mg_last   = ({1'b0, r_v} == nv_m1);

    // memory port steering
    always_comb begin
        cov_we = 1'b0;
        cov_wa = r_clr_cnt[VTX_W-1:0];
        cov_wd = r_clr_cnt[VTX_W-1:0];
        if (clr_busy && (r_clr_cnt[CLR_W-1:VTX_W] == '0)) begin
            cov_we = 1'b1;                         // identity labels
        end else if (r_state == S_MG && r_p_act && r_cov_rd == r_ca) begin
            cov_we = 1'b1;
            cov_wa = r_p_i;
            cov_wd = r_cb;
        end
    end
    assign cov_ra = r_v;

    always_comb begin
        dist_we = 1'b0;
        dist_wa = r_clr_cnt[DADDR_W-1:0];
        dist_wd = '0;
        if (clr_busy) begin
            dist_we = 1'b1;
        end else if (ld_ok) begin
            dist_we = 1'b1;
            dist_wa = {r_va, r_vb};
            dist_wd = {1'b1, r_dist};
        end else if (r_state == S_LD1) begin
            dist_we = 1'b1;
            dist_wa = {r_vb, r_va};
            dist_wd = {1'b1, r_dist};
        end
    end
    assign edge_we = ld_ok;

    always_ff @(posedge i_clk) begin
        if (cov_we) begin
            m_cov[cov_wa] <= cov_wd;
        end
        r_cov_rd <= m_cov[cov_ra];
    end

    always_ff @(posedge i_clk) begin
        if (dist_we) begin
            m_dist[dist_wa] <= dist_wd;
        end
        r_fw_rd <= m_dist[{r_i, r_j}];
        r_bw_rd <= m_dist[{r_j, r_i}];
    end

    always_ff @(posedge i_clk) begin
        if (edge_we) begin
            m_edge[r_edge_cnt[EDGE_W-1:0]] <= {r_va, r_vb};
        end
        r_edge_rd <= m_edge[r_k];
    end

    // ---------------------------------------------------------------
    // Pair scan compare: forward direction first, then backward
    // ---------------------------------------------------------------
    assign fw_d = r_fw_rd[DIST_BITS-1:0];
    assign bw_d = r_bw_rd[DIST_BITS-1:0];
    assign fw_take = r_fw_rd[DIST_BITS] &&
                     (!r_found || (r_pick ? (fw_d > r_best) : (fw_d < r_best)));
    assign bw_take = r_bw_rd[DIST_BITS] &&
                     (!r_found || (r_pick ? (bw_d > r_best) : (bw_d < r_best)));

    always_comb begin
        n_found = r_found;
        n_best  = r_best;
        n_bi    = r_bi;
        n_bj    = r_bj;
        if (r_state == S_FS && r_p_v) begin
            if (fw_take) begin
                n_found = 1'b1;
                n_best  = fw_d;
                n_bi    = r_p_i;
                n_bj    = r_p_j;
            end else if (bw_take) begin
                n_found = 1'b1;
                n_best  = bw_d;
                n_bi    = r_p_j;
                n_bj    = r_p_i;
            end
        end
    end

    // first listed edge joining the chosen pair, either orientation
    assign edge_hit = ((r_edge_rd[2*VTX_W-1:VTX_W] == r_bi) && (r_edge_rd[VTX_W-1:0] == r_bj)) ||
                      ((r_edge_rd[2*VTX_W-1:VTX_W] == r_bj) && (r_edge_rd[VTX_W-1:0] == r_bi));

    assign out_free = !r_out_v || i_ready;

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_nv_cfg   <= NV_W'(MAX_VERTICES);
            r_pick     <= 1'b0;
            r_live     <= '1;
            r_edge_cnt <= '0;
            r_clr_cnt  <= '0;
            r_issue    <= 1'b0;
            r_p_act    <= 1'b0;
            r_p_v      <= 1'b0;
            r_p_last   <= 1'b0;
            r_found    <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            if (clr_busy) begin
                r_clr_cnt <= r_clr_cnt + CLR_W'(1);
            end

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_NUM_VERTICES: r_nv_cfg <= i_cfg_data;
                    CFG_PICK_LONGEST: r_pick   <= i_cfg_data[0];
                    default: ;
                endcase
            end

            if (r_out_v && i_ready) begin
                r_out_v <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    r_p_act <= 1'b0;
                    r_p_v   <= 1'b0;
                    if (i_valid && o_ready) begin
                        r_func  <= i_func;
                        r_va    <= i_vertex_a;
                        r_vb    <= i_vertex_b;
                        r_dist  <= i_distance;
                        r_ca    <= i_cluster_a;
                        r_cb    <= i_cluster_b;
                        r_state <= S_CHK;
                    end
                end

                S_CHK: begin
                    r_res_idx  <= '0;
                    r_res_dist <= '0;
                    r_res_stat <= STAT_OK;
                    r_v        <= '0;
                    r_issue    <= 1'b1;
                    case (r_func)
                        FUNC_LOAD: r_state <= S_LD0;
                        FUNC_FIND, FUNC_MERGE: begin
                            if (!ca_ok || !cb_ok) begin
                                r_res_stat <= STAT_MISSING;
                                r_state    <= S_DONE;
                            end else begin
                                r_state <= (r_func == FUNC_FIND) ? S_FM : S_MG;
                            end
                        end
                        default: r_state <= S_DONE;      // no operation
                    endcase
                end

                S_LD0: begin
                    if (!ld_range_ok) begin
                        r_res_stat <= STAT_MISSING;
                        r_state    <= S_DONE;
                    end else if (ld_full) begin
                        r_res_stat <= STAT_FULL;
                        r_state    <= S_DONE;
                    end else begin
                        r_edge_cnt <= r_edge_cnt + ECNT_W'(1);
                        r_state    <= S_LD1;
                    end
                end

                S_LD1: r_state <= S_DONE;

                S_FM: begin
                    // issue one label read per cycle over all vertices
                    r_p_act  <= r_issue;
                    r_p_i    <= r_v;
                    r_p_last <= r_issue && (r_v == VTX_W'(MAX_VERTICES - 1));
                    if (r_issue) begin
                        r_v <= r_v + VTX_W'(1);
                        if (r_v == VTX_W'(MAX_VERTICES - 1)) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_p_act) begin
                        r_mask_a[r_p_i] <= (r_cov_rd == r_ca);
                        r_mask_b[r_p_i] <= (r_cov_rd == r_cb);
                        if (r_p_last) begin
                            r_i      <= '0;
                            r_j      <= '0;
                            r_issue  <= 1'b1;
                            r_found  <= 1'b0;
                            r_p_act  <= 1'b0;
                            r_p_last <= 1'b0;
                            r_state  <= S_FS;
                        end
                    end
                end

                S_FS: begin
                    r_p_act  <= r_issue;
                    r_p_v    <= r_issue && r_mask_a[r_i] && r_mask_b[r_j];
                    r_p_i    <= r_i;
                    r_p_j    <= r_j;
                    r_p_last <= r_issue && scan_last;
                    if (r_issue) begin
                        if ({1'b0, r_j} == nv_m1) begin
                            r_j <= '0;
                            r_i <= r_i + VTX_W'(1);
                        end else begin
                            r_j <= r_j + VTX_W'(1);
                        end
                        if (scan_last) begin
                            r_issue <= 1'b0;
                        end
                    end
                    r_found <= n_found;
                    r_best  <= n_best;
                    r_bi    <= n_bi;
                    r_bj    <= n_bj;
                    if (r_p_act && r_p_last) begin
                        r_p_act  <= 1'b0;
                        r_p_v    <= 1'b0;
                        r_p_last <= 1'b0;
                        r_k      <= '0;
                        if (!n_found || r_edge_cnt == '0) begin
                            r_res_stat <= STAT_NOLINK;
                            r_state    <= S_DONE;
                        end else begin
                            r_issue <= 1'b1;
                            r_state <= S_FE;
                        end
                    end
                end

                S_FE: begin
                    r_p_act  <= r_issue;
                    r_p_k    <= r_k;
                    r_p_last <= r_issue && fe_last;
                    if (r_issue) begin
                        r_k <= r_k + EDGE_W'(1);
                        if (fe_last) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_p_act) begin
                        if (edge_hit) begin
                            r_res_idx  <= r_p_k;
                            r_res_dist <= r_best;
                            r_res_stat <= STAT_OK;
                            r_issue    <= 1'b0;
                            r_state    <= S_DONE;
                        end else if (r_p_last) begin
                            r_res_stat <= STAT_NOLINK;
                            r_state    <= S_DONE;
                        end
                    end
                end

                S_MG: begin
                    // read label v while writing back label v-1
                    r_p_act  <= r_issue;
                    r_p_i    <= r_v;
                    r_p_last <= r_issue && mg_last;
                    if (r_issue) begin
                        r_v <= r_v + VTX_W'(1);
                        if (mg_last) begin
                            r_issue <= 1'b0;
                        end
                    end
                    if (r_p_act && r_p_last) begin
                        if (r_ca != r_cb) begin
                            r_live[r_ca] <= 1'b0;
                        end
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    r_issue <= 1'b0;
                    if (out_free) begin
                        r_out_v    <= 1'b1;
                        r_out_idx  <= r_res_idx;
                        r_out_dist <= r_res_dist;
                        r_out_stat <= r_res_stat;
                        r_state    <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE) && !clr_busy;
    assign o_valid         = r_out_v;
    assign o_edge_index    = r_out_idx;
    assign o_best_distance = r_out_dist;
    assign o_status        = r_out_stat;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `CLSM_ASSERT_IMP(a_no_accept_in_clear, i_clk, i_rst_n, clr_busy, !o_ready, "item taken during clear")
    `CLSM_ASSERT_IMP(a_err_fields_zero, i_clk, i_rst_n, o_valid && o_status != STAT_OK, o_edge_index == '0 && o_best_distance == '0, "nonzero fields on error")
    `CLSM_ASSERT_IMP(a_edge_cnt_bound, i_clk, i_rst_n, 1'b1, r_edge_cnt <= ECNT_W'(MAX_EDGES), "edge count overflow")
    `CLSM_ASSERT_NXT(a_done_hands_off, i_clk, i_rst_n, r_state == S_DONE && out_free, o_valid && r_state == S_IDLE, "result lost")

endmodule
